@@ hdl/salc_pkg.sv @@
// Package with the shared constants, types and controller states of the LRU cache.
`default_nettype none
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int TAG_WIDTH    = 32;
    localparam int STAMP_WIDTH  = 32;

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SB_W      = $clog2(MAX_SET_BITS + 2);
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
    localparam int TOTAL_W   = 32;

    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_W       = 4;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    localparam logic [1:0] MODE_FETCH  = 2'd0;
    localparam logic [1:0] MODE_LS     = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    typedef struct packed {
        logic                   valid;
        logic [TAG_WIDTH-1:0]   tag;
        logic [STAMP_WIDTH-1:0] stamp;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

@@ hdl/salc_ctrl.sv @@
// Controller state machine that sequences one cache access at a time.
`default_nettype none
module salc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  salc_pkg::t_status   i_status,
    output salc_pkg::t_cmd      o_cmd
);
    import salc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.eval = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_EVAL: begin
                o_cmd.eval = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/salc_dp.sv @@
// Datapath of the LRU cache: configuration, set memory, lookup, replacement and counters.
`default_nettype none
module salc_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  salc_pkg::t_cmd                       i_cmd,
    output salc_pkg::t_status                    o_status,
    input  wire                                  i_cfg_we,
    input  wire [salc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [salc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire [1:0]                            i_mode,
    input  wire [63:0]                           i_access_address,
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_was_hit,
    output logic                                 o_was_miss,
    output logic                                 o_was_eviction,
    output logic [salc_pkg::TOTAL_W-1:0]         o_hit_total,
    output logic [salc_pkg::TOTAL_W-1:0]         o_miss_total,
    output logic [salc_pkg::TOTAL_W-1:0]         o_eviction_total
);
    import salc_pkg::*;

    localparam int NP = 1 << WAY_W;

    typedef struct packed {
        logic                   en;
        logic [STAMP_WIDTH-1:0] stamp;
        logic [WAY_W-1:0]       idx;
    } t_cand;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                   input logic [1:0] inc);
        logic [TOTAL_W:0] s;
        s = {1'b0, v} + {{(TOTAL_W-1){1'b0}}, inc};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    // Configuration registers.
    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [BLOCK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]       r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= WAYS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                default:        r_set_bits   <= r_set_bits;
            endcase
        end
    end

    // Address split for the incoming access.
    logic [63:0]          rest;
    logic [SB_W-1:0]      sb;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     n_set;
    logic [63:0]          tag_full;

    always_comb begin
        rest     = i_access_address >> r_block_bits;
        sb       = (int'(r_set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(r_set_bits);
        set_mask = SET_W'((1 << sb) - 1);
        n_set    = rest[SET_W-1:0] & set_mask;
        tag_full = rest >> sb;
    end

    logic [WCNT_W-1:0] ways_eff;
    always_comb begin
        if (r_ways == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(r_ways);
        end
    end

    // Item registers and the stamp counter.
    logic [1:0]             r_mode;
    logic [SET_W-1:0]       r_set;
    logic [TAG_WIDTH-1:0]   r_tag;
    logic [STAMP_WIDTH-1:0] r_tick;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_set  <= n_set;
            r_tag  <= tag_full[TAG_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_cmd.load && (r_tick != {STAMP_WIDTH{1'b1}})) begin
            r_tick <= r_tick + STAMP_WIDTH'(1);
        end
    end

    // Set memory, one row per set, with a valid flop per row cleared at reset.
    t_row                r_mem [NUM_SETS];
    t_row                r_rd_row;
    logic                r_rd_vld;
    logic [NUM_SETS-1:0] r_row_vld;
    t_row                n_row;
    logic                wr_en;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_row <= r_mem[n_set];
        end
        if (wr_en) begin
            r_mem[r_set] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.load) r_rd_vld <= r_row_vld[n_set];
            if (wr_en) r_row_vld[r_set] <= 1'b1;
        end
    end

    // Lookup and replacement choice.
    t_row              lines;
    logic              active;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              has_free;
    logic [WAY_W-1:0]  free_way;
    t_cand             cand [2*NP];
    logic [WAY_W-1:0]  tgt_way;
    logic              evict;

    always_comb begin
        lines    = r_rd_vld ? r_rd_row : '0;
        active   = (r_mode == MODE_LS) || (r_mode == MODE_MODIFY);
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (WCNT_W'(w) < ways_eff) begin
                if (lines[w].valid && (lines[w].tag == r_tag)) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!lines[w].valid) begin
                    has_free = 1'b1;
                    free_way = WAY_W'(w);
                end
            end
        end
        for (int i = 0; i < NP; i++) begin
            cand[NP+i].en    = (i < MAX_WAYS) ? (WCNT_W'(i) < ways_eff) : 1'b0;
            cand[NP+i].stamp = (i < MAX_WAYS) ? lines[i % MAX_WAYS].stamp : '0;
            cand[NP+i].idx   = WAY_W'(i);
        end
        cand[0] = '0;
        // Left child always holds the lower ways, so ties keep the lowest index.
        for (int n = NP - 1; n >= 1; n--) begin
            if (!cand[2*n].en) begin
                cand[n] = cand[2*n+1];
            end else if (cand[2*n+1].en && (cand[2*n+1].stamp < cand[2*n].stamp)) begin
                cand[n] = cand[2*n+1];
            end else begin
                cand[n] = cand[2*n];
            end
        end
        evict = active && !hit && !has_free;
        if (hit) begin
            tgt_way = hit_way;
        end else if (has_free) begin
            tgt_way = free_way;
        end else begin
            tgt_way = (NP > 1) ? cand[1].idx : '0;
        end
        n_row = lines;
        n_row[tgt_way].valid = 1'b1;
        n_row[tgt_way].tag   = r_tag;
        n_row[tgt_way].stamp = r_tick;
        wr_en = i_cmd.eval && active;
    end

    // Result register and running totals.
    logic [1:0] hit_inc;
    assign hit_inc = {1'b0, active && hit} + {1'b0, r_mode == MODE_MODIFY};

    logic r_out_valid;
    logic r_hit;
    logic r_miss;
    logic r_evict;
    logic [TOTAL_W-1:0] r_hit_cnt;
    logic [TOTAL_W-1:0] r_miss_cnt;
    logic [TOTAL_W-1:0] r_evict_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_out_valid <= 1'b1;
                r_hit_cnt   <= sat_add(r_hit_cnt, hit_inc);
                r_miss_cnt  <= sat_add(r_miss_cnt, {1'b0, active && !hit});
                r_evict_cnt <= sat_add(r_evict_cnt, {1'b0, evict});
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_hit   <= active && hit;
            r_miss  <= active && !hit;
            r_evict <= evict;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_was_hit         = r_hit;
    assign o_was_miss        = r_miss;
    assign o_was_eviction    = r_evict;
    assign o_hit_total       = r_hit_cnt;
    assign o_miss_total      = r_miss_cnt;
    assign o_eviction_total  = r_evict_cnt;

endmodule
`default_nettype wire

@@ hdl/set_assoc_lru_cache_sim.sv @@
// Top level of the set-associative cache model with LRU replacement.
//
//  Channel   Direction  Handshake           Payload
//  access    in         i_valid / o_ready   i_mode, i_access_address
//  result    out        o_valid / i_ready   o_was_hit, o_was_miss, o_was_eviction, totals
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// Each access has an accept step, which splits the address and reads the whole
// set row from the set memory, and an evaluate step, which compares all ways,
// picks the LRU victim and writes the row back. The single memory read and
// write port per access keeps the steps apart. A result waits in an output
// register; the next item is accepted meanwhile, and its evaluation holds
// only while the previous result has not been taken. After reset all lines
// read as invalid at once, since each set row has a valid flop cleared by reset.
`default_nettype none
module set_assoc_lru_cache_sim (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire [1:0]                          i_mode,
    input  wire [63:0]                         i_access_address,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic                               o_was_hit,
    output logic                               o_was_miss,
    output logic                               o_was_eviction,
    output logic [salc_pkg::TOTAL_W-1:0]       o_hit_total,
    output logic [salc_pkg::TOTAL_W-1:0]       o_miss_total,
    output logic [salc_pkg::TOTAL_W-1:0]       o_eviction_total,
    input  wire                                i_cfg_we,
    input  wire [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import salc_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd    cmd;
    t_status status;

    salc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath owns the configuration, set memory, counters and result register.
    salc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_access_address (i_access_address),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_was_hit        (o_was_hit),
        .o_was_miss       (o_was_miss),
        .o_was_eviction   (o_was_eviction),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

endmodule
`default_nettype wire

@@ sim/set_assoc_lru_cache_sim_tb.sv @@
// Self-checking testbench for the LRU cache: predicted lookup outcomes checked against every result.
module set_assoc_lru_cache_sim_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    // The register index and the access mode that the block has no use for.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [1:0]           MODE_RESERVED = 2'd3;

    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
    // The limit is set well above what a slow correct run (both sides idling,
    // one long hold-off) needs, so it leaves ample margin.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_STALL_RUN = 12;
    localparam int MAX_GAP       = 30;
    localparam int PRINT_CAP     = 40;

    localparam logic [TOTAL_W-1:0]     TOTAL_TOP = '1;
    localparam logic [STAMP_WIDTH-1:0] STAMP_TOP = '1;

    // One result item, in the order of the output ports.
    typedef struct packed {
        logic               hit;
        logic               miss;
        logic               evict;
        logic [TOTAL_W-1:0] hits;
        logic [TOTAL_W-1:0] misses;
        logic [TOTAL_W-1:0] evicts;
    } t_access_outcome;

    // The scoreboard keeps its own copy of the cache: lines, timestamps,
    // totals and the three registers. Each accepted access is run through it
    // at once, and the outcome waits in a queue for the block's result.
    class lru_scoreboard;
        logic [SET_BITS_W-1:0]   set_bits_r;
        logic [BLOCK_BITS_W-1:0] block_bits_r;
        logic [WAYS_W-1:0]       ways_r;
        bit                      line_valid [NUM_LINES];
        logic [TAG_WIDTH-1:0]    line_tag   [NUM_LINES];
        logic [STAMP_WIDTH-1:0]  line_stamp [NUM_LINES];
        logic [STAMP_WIDTH-1:0]  tick;
        logic [TOTAL_W-1:0]      hit_count;
        logic [TOTAL_W-1:0]      miss_count;
        logic [TOTAL_W-1:0]      evict_count;
        t_access_outcome         outcome_q [$];
        int unsigned             mismatches;
        int unsigned             results_checked;
        int unsigned             ignored_count;
        int unsigned             hits_seen;
        int unsigned             misses_seen;
        int unsigned             evictions_seen;

        function new();
            set_bits_r   = '0;
            block_bits_r = '0;
            ways_r       = WAYS_W'(1);
            foreach (line_valid[i]) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            tick            = '0;
            hit_count       = '0;
            miss_count      = '0;
            evict_count     = '0;
            mismatches      = 0;
            results_checked = 0;
            ignored_count   = 0;
            hits_seen       = 0;
            misses_seen     = 0;
            evictions_seen  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:   set_bits_r   = data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_r = data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       ways_r       = data[WAYS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
            return (v == TOTAL_TOP) ? v : v + 1'b1;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_access(logic [1:0] mode, logic [63:0] addr);
            t_access_outcome want;
            int              sb;
            int              ways;
            int              base;
            int              victim;
            logic [63:0]     rest;
            logic [TAG_WIDTH-1:0] tag;
            bit              found;
            want = '0;
            if (tick != STAMP_TOP)
                tick = tick + 1'b1;
            if (mode == MODE_LS || mode == MODE_MODIFY) begin
                sb   = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_r);
                ways = (ways_r == 0) ? 1 : (ways_r > MAX_WAYS) ? MAX_WAYS : int'(ways_r);
                rest = addr >> block_bits_r;
                base = int'(rest & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
                tag  = TAG_WIDTH'(rest >> sb);
                found = 1'b0;
                for (int w = 0; w < ways && !found; w++) begin
                    if (line_valid[base + w] && line_tag[base + w] == tag) begin
                        line_stamp[base + w] = tick;
                        want.hit = 1'b1;
                        found    = 1'b1;
                    end
                end
                if (!found) begin
                    want.miss = 1'b1;
                    for (int w = 0; w < ways && !found; w++) begin
                        if (!line_valid[base + w]) begin
                            line_valid[base + w] = 1'b1;
                            line_tag[base + w]   = tag;
                            line_stamp[base + w] = tick;
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    // Every way is taken: replace the oldest, lowest way on a tie.
                    want.evict = 1'b1;
                    victim = 0;
                    for (int w = 1; w < ways; w++)
                        if (line_stamp[base + w] < line_stamp[base + victim])
                            victim = w;
                    line_tag[base + victim]   = tag;
                    line_stamp[base + victim] = tick;
                end
                if (want.hit)
                    hit_count = bump(hit_count);
                if (want.miss)
                    miss_count = bump(miss_count);
                if (want.evict)
                    evict_count = bump(evict_count);
                if (mode == MODE_MODIFY)
                    hit_count = bump(hit_count);
            end else begin
                ignored_count++;
            end
            want.hits   = hit_count;
            want.misses = miss_count;
            want.evicts = evict_count;
            outcome_q.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(t_access_outcome got);
            t_access_outcome want;
            if (outcome_q.size() == 0) begin
                report_mismatch($sformatf("result with no access outstanding (hit %0b miss %0b)",
                                          got.hit, got.miss));
            end else begin
                want = outcome_q.pop_front();
                results_checked++;
                hits_seen      += want.hit;
                misses_seen    += want.miss;
                evictions_seen += want.evict;
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("result %0d was_hit %b, expected %b",
                                              results_checked, got.hit, want.hit));
                if (got.miss !== want.miss)
                    report_mismatch($sformatf("result %0d was_miss %b, expected %b",
                                              results_checked, got.miss, want.miss));
                if (got.evict !== want.evict)
                    report_mismatch($sformatf("result %0d was_eviction %b, expected %b",
                                              results_checked, got.evict, want.evict));
                if (got.hits !== want.hits)
                    report_mismatch($sformatf("result %0d hit_total %0d, expected %0d",
                                              results_checked, got.hits, want.hits));
                if (got.misses !== want.misses)
                    report_mismatch($sformatf("result %0d miss_total %0d, expected %0d",
                                              results_checked, got.misses, want.misses));
                if (got.evicts !== want.evicts)
                    report_mismatch($sformatf("result %0d eviction_total %0d, expected %0d",
                                              results_checked, got.evicts, want.evicts));
            end
        endtask
    endclass

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_valid          = 1'b0;
    logic [1:0]              i_mode           = MODE_FETCH;
    logic [63:0]             i_access_address = '0;
    logic                    i_ready          = 1'b0;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index      = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0]   i_cfg_data       = '0;
    logic                    o_ready;
    logic                    o_valid;
    logic                    o_was_hit;
    logic                    o_was_miss;
    logic                    o_was_eviction;
    logic [TOTAL_W-1:0]      o_hit_total;
    logic [TOTAL_W-1:0]      o_miss_total;
    logic [TOTAL_W-1:0]      o_eviction_total;

    // Idle and stall rates in percent for the current phase, and the flag
    // that holds the receiver off during the back-pressure stretch.
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    logic        rx_hold       = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned settings_run  = 1;
    int unsigned items_sent    = 0;

    lru_scoreboard scb;

    set_assoc_lru_cache_sim i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_access_address (i_access_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_was_hit        (o_was_hit),
        .o_was_miss       (o_was_miss),
        .o_was_eviction   (o_was_eviction),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offers one access, after a random number of idle cycles, and returns at
    // the edge where the block takes it. The scoreboard learns of the access
    // at that same edge, well before its result can come out.
    task automatic send_access(logic [1:0] mode, logic [63:0] addr);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_mode           <= mode;
        i_access_address <= addr;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        scb.note_access(mode, addr);
        items_sent++;
    endtask

    // Waits until every outstanding result has been taken, then waits on so
    // that the block's pipeline is certainly empty.
    task automatic wait_idle();
        while (scb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Drops valid in the step of the last acceptance, lets the block drain,
    // then writes all three registers and the unused index back to back.
    task automatic program_cache(logic [CFG_DATA_W-1:0] sb_val,
                                 logic [CFG_DATA_W-1:0] bb_val,
                                 logic [CFG_DATA_W-1:0] ways_val);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_SET_BITS, CFG_BLOCK_BITS, CFG_WAYS, CFG_SPARE};
        val = '{sb_val, bb_val, ways_val, CFG_DATA_W'($urandom)};
        i_valid <= 1'b0;
        wait_idle();
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            scb.write_register(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Holds the receiver off for a long stretch so results back up and the
    // block has to stall its input.
    task automatic hold_receiver(int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // One random phase under one setting. Most accesses reuse a handful of
    // sets and a tag pool a little larger than the ways, so that hits,
    // fills and LRU evictions all come up; the rest are fully random
    // addresses and ignored modes.
    task automatic run_phase(logic [CFG_DATA_W-1:0] sb_val, logic [CFG_DATA_W-1:0] bb_val,
                             logic [CFG_DATA_W-1:0] ways_val, int tx_pct, int rx_pct,
                             int count, bit squeeze);
        int                   sb;
        int                   bb;
        int                   ways;
        int                   kind;
        int                   hot_sets;
        logic [63:0]          noise;
        logic [63:0]          addr;
        logic [63:0]          set_mask;
        logic [63:0]          tag_mask;
        logic [63:0]          set_idx;
        logic [TAG_WIDTH-1:0] tag;
        logic [1:0]           mode;
        program_cache(sb_val, bb_val, ways_val);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sb   = (sb_val > MAX_SET_BITS) ? MAX_SET_BITS : int'(sb_val);
        bb   = int'(bb_val);
        ways = (ways_val[WAYS_W-1:0] == 0) ? 1 :
               (ways_val[WAYS_W-1:0] > MAX_WAYS) ? MAX_WAYS : int'(ways_val[WAYS_W-1:0]);
        hot_sets = ((1 << sb) < 4) ? (1 << sb) : 4;
        set_mask = ((64'd1 << sb) - 64'd1) << bb;
        tag_mask = 64'hFFFF_FFFF << (bb + sb);
        if (squeeze)
            fork
                hold_receiver(HOLD_CYCLES);
            join_none
        for (int n = 0; n < count; n++) begin
            noise = {$urandom, $urandom};
            kind  = $urandom_range(99);
            if (kind < 8) begin
                mode = $urandom_range(1) ? MODE_FETCH : MODE_RESERVED;
                addr = noise;
            end else if (kind < 16) begin
                mode = $urandom_range(1) ? MODE_LS : MODE_MODIFY;
                addr = noise;
            end else begin
                mode = ($urandom_range(99) < 70) ? MODE_LS : MODE_MODIFY;
                if ($urandom_range(9) == 0)
                    set_idx = $urandom_range((1 << sb) - 1);
                else
                    set_idx = $urandom_range(hot_sets - 1);
                case ($urandom_range(19))
                    0:       tag = '1;
                    1:       tag = $urandom;
                    default: tag = $urandom_range(ways + 2);
                endcase
                // Keep the offset and the bits above the tag random.
                addr = (noise & ~(set_mask | tag_mask))
                     | ((set_idx << bb) & set_mask)
                     | ((64'(tag) << (bb + sb)) & tag_mask);
            end
            send_access(mode, addr);
        end
    endtask

    // Result side: checks every item taken, then picks ready for the next
    // cycle. Stall runs are capped so a phase cannot starve by chance.
    initial begin : result_sink
        t_access_outcome got;
        int              stall_run;
        stall_run = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready) begin
                got = {o_was_hit, o_was_miss, o_was_eviction,
                       o_hit_total, o_miss_total, o_eviction_total};
                scb.check_result(got);
            end
            if (rx_hold || (stall_run < MAX_STALL_RUN && $urandom_range(99) < rx_stall_pct)) begin
                i_ready <= 1'b0;
                stall_run++;
            end else begin
                i_ready   <= 1'b1;
                stall_run = 0;
            end
        end
    end

    // Cycle counter and time limit.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, scb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        scb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: no set bits, no offset, one way. The tag is the low
        // 32 address bits, so every new tag replaces the single line.
        send_access(MODE_FETCH, 64'd0);
        send_access(MODE_RESERVED, '1);
        send_access(MODE_LS, 64'd0);
        send_access(MODE_LS, 64'd0);
        send_access(MODE_MODIFY, 64'd0);
        send_access(MODE_LS, 64'd1);
        send_access(MODE_MODIFY, '1);
        send_access(MODE_LS, 64'hFFFF_FFFF_0000_0001);

        // Four sets, 16-byte lines, two ways: fill set 0, hit, then evict the
        // older line twice over.
        program_cache(6'd2, 6'd4, 6'd2);
        send_access(MODE_LS, 64'h000);
        send_access(MODE_LS, 64'h040);
        send_access(MODE_LS, 64'h000);
        send_access(MODE_LS, 64'h080);
        send_access(MODE_LS, 64'h040);
        send_access(MODE_MODIFY, 64'h010);

        // Set bits above the maximum, the widest offset and zero ways. Lines
        // from the previous setting stay in place and are looked up anew.
        program_cache(6'd7, 6'd63, 6'd0);
        send_access(MODE_LS, '1);
        send_access(MODE_LS, 64'h8000_0000_0000_0000);
        send_access(MODE_LS, 64'd0);

        // An offset above 32 bits and more ways than exist.
        program_cache(6'd6, 6'd40, 6'd15);
        send_access(MODE_LS, 64'hFFFF_FF00_0000_0000);
        send_access(MODE_LS, 64'hFFFF_FF12_3456_789A);
        send_access(MODE_MODIFY, 64'h00AB_CD00_0000_0000);

        program_cache(6'd3, 6'd32, 6'd8);
        send_access(MODE_LS, 64'd0);
        send_access(MODE_LS, 64'h0000_0001_0000_0000);

        // Random phases: each idling pattern comes up twice, and one phase
        // holds the receiver off for a long stretch.
        run_phase(6'd0, 6'd0,  6'd1,  0,  0,  210, 1'b0);
        run_phase(6'd3, 6'd6,  6'd4,  73, 0,  210, 1'b0);
        run_phase(6'd6, 6'd32, 6'd8,  0,  73, 210, 1'b0);
        run_phase(6'd7, 6'd63, 6'd15, 31, 31, 210, 1'b0);
        run_phase(6'd2, 6'd5,  6'd0,  0,  0,  210, 1'b1);
        run_phase(6'd1, 6'd12, 6'd2,  73, 0,  210, 1'b0);
        run_phase(6'd4, 6'd33, 6'd3,  0,  73, 210, 1'b0);
        run_phase(6'd5, 6'd0,  6'd8,  31, 31, 210, 1'b0);

        i_valid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d accesses (%0d ignored) under %0d cache settings, with sender gaps,",
                 items_sent, scb.ignored_count, settings_run);
        $display("receiver stalls and a long hold-off: %0d results, %0d hits, %0d misses,",
                 scb.results_checked, scb.hits_seen, scb.misses_seen);
        $display("and %0d evictions.", scb.evictions_seen);
        if (scb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
